// ===== rtl/core/tour_two_opt_engine_assert.svh =====
// Assertion macros shared by the engine's modules.
`ifndef TOUR_TWO_OPT_ENGINE_ASSERT_SVH
`define TOUR_TWO_OPT_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TTO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TTO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TTO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/tto_pkg.sv =====
package tto_pkg;

	localparam int CITY_COUNT_DEF    = 64;
	localparam int COORD_BITS_DEF    = 10;
	localparam int FRACTION_BITS_DEF = 4;

	localparam int CMD_W      = 3;
	localparam int IDX_W      = 6;
	localparam int IDX_EXT_W  = 11;
	localparam int CITY_W     = 10;
	localparam int CRD_EXT_W  = 16;
	localparam int LEN_W      = 21;
	localparam int ADDR_MAX_W = 10;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 3'd0,
		CMD_SWAP = 3'd1,
		CMD_REV  = 3'd2,
		CMD_TEST = 3'd3,
		CMD_LEN  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_CAP,
		ST_DST,
		ST_WAIT,
		ST_WR1,
		ST_WR2,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_BEN,
		OUT_LEN
	} out_kind_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_MAX_W-1:0] rd_addr;
		logic                  cap1;
		logic                  cap2;
		logic                  wr_en;
		logic [ADDR_MAX_W-1:0] wr_addr;
		logic                  wr_src_p2;
		logic                  wr_load;
		logic                  dist_start;
		logic                  acc_clr;
		logic                  acc_add_sel;
		logic                  acc_sat;
		logic                  out_load;
		out_kind_t             out_kind;
	} dp_ctrl_t;

	typedef struct packed {
		logic dist_done;
	} dp_stat_t;

endpackage

// ===== rtl/core/tto_dist.sv =====
`include "tour_two_opt_engine_assert.svh"

module tto_dist #(
	parameter int COORD_BITS    = tto_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = tto_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [COORD_BITS-1:0]               ax,
	input  logic [COORD_BITS-1:0]               ay,
	input  logic [COORD_BITS-1:0]               bx,
	input  logic [COORD_BITS-1:0]               by,
	output logic                                done,
	output logic [COORD_BITS+FRACTION_BITS:0]   dist_len
);

	localparam int QW    = COORD_BITS + FRACTION_BITS + 1;
	localparam int RAD_W = 2 * QW;
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int REM_W = QW + 2;
	localparam int CW    = $clog2(QW + 1);

	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;
	logic                  v_s1, v_s2;
	logic                  run_q, done_q;
	logic [CW-1:0]         cnt_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [QW-1:0]         root_q;
	logic [SQ_W:0]         sum;
	logic [REM_W+1:0]      rem_n, trial;
	logic                  busy;

	assign sum   = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);
	assign rem_n = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign busy  = v_s1 | v_s2 | run_q | done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= 1'b0;
			if (v_s2) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= CW'(cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_s1 <= (ax > bx) ? COORD_BITS'(ax - bx) : COORD_BITS'(bx - ax);
			dy_s1 <= (ay > by) ? COORD_BITS'(ay - by) : COORD_BITS'(by - ay);
		end
		if (v_s1) begin
			sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		end
		if (v_s2) begin
			rad_q  <= RAD_W'(sum) << (2 * FRACTION_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			// one root bit per cycle, restoring
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= REM_W'(rem_n - trial);
				root_q <= {root_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_n);
				root_q <= {root_q[QW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign dist_len = root_q;

	`TTO_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy)

endmodule

// ===== rtl/core/tto_datapath.sv =====
module tto_datapath #(
	parameter int CITY_COUNT    = tto_pkg::CITY_COUNT_DEF,
	parameter int COORD_BITS    = tto_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = tto_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tto_pkg::dp_ctrl_t             ctl,
	output tto_pkg::dp_stat_t             stat,
	input  logic [tto_pkg::CITY_W-1:0]    city_x,
	input  logic [tto_pkg::CITY_W-1:0]    city_y,
	output logic                          beneficial,
	output logic [tto_pkg::LEN_W-1:0]     tour_length
);

	localparam int AW    = (CITY_COUNT > 1) ? $clog2(CITY_COUNT) : 1;
	localparam int QW    = COORD_BITS + FRACTION_BITS + 1;
	localparam int ACC_W = (QW + 1 > tto_pkg::LEN_W) ? QW + 1 : tto_pkg::LEN_W;

	logic [COORD_BITS-1:0] mem_x [CITY_COUNT];
	logic [COORD_BITS-1:0] mem_y [CITY_COUNT];

	logic [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic [COORD_BITS-1:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic [COORD_BITS-1:0] wx, wy;
	logic [tto_pkg::CRD_EXT_W-1:0] cx_ext, cy_ext;
	logic [ACC_W-1:0] acc_rem_q, acc_add_q;
	logic [ACC_W:0]   rem_sum;
	logic [QW-1:0]    d;
	logic             d_done;
	logic             ben_q;
	logic [tto_pkg::LEN_W-1:0] len_q;

	assign cx_ext = tto_pkg::CRD_EXT_W'(city_x);
	assign cy_ext = tto_pkg::CRD_EXT_W'(city_y);

	always_comb begin
		if (ctl.wr_load) begin
			wx = cx_ext[COORD_BITS-1:0];
			wy = cy_ext[COORD_BITS-1:0];
		end else if (ctl.wr_src_p2) begin
			wx = p2x_q;
			wy = p2y_q;
		end else begin
			wx = p1x_q;
			wy = p1y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_x[ctl.wr_addr[AW-1:0]] <= wx;
			mem_y[ctl.wr_addr[AW-1:0]] <= wy;
		end
		if (ctl.rd_en) begin
			rd_x_q <= mem_x[ctl.rd_addr[AW-1:0]];
			rd_y_q <= mem_y[ctl.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap1) begin
			p1x_q <= rd_x_q;
			p1y_q <= rd_y_q;
		end
		if (ctl.cap2) begin
			p2x_q <= rd_x_q;
			p2y_q <= rd_y_q;
		end
	end

	tto_dist #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.dist_start),
		.ax       (p1x_q),
		.ay       (p1y_q),
		.bx       (p2x_q),
		.by       (p2y_q),
		.done     (d_done),
		.dist_len (d)
	);

	assign stat.dist_done = d_done;
	assign rem_sum = (ACC_W+1)'(acc_rem_q) + (ACC_W+1)'(d);

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_rem_q <= '0;
			acc_add_q <= '0;
		end else if (d_done) begin
			if (ctl.acc_add_sel) begin
				acc_add_q <= ACC_W'(acc_add_q + ACC_W'(d));
			end else if (ctl.acc_sat && rem_sum > (ACC_W+1)'(tto_pkg::LEN_MAX)) begin
				acc_rem_q <= ACC_W'(tto_pkg::LEN_MAX);
			end else begin
				acc_rem_q <= ACC_W'(rem_sum);
			end
		end
		if (ctl.out_load) begin
			ben_q <= (ctl.out_kind == tto_pkg::OUT_BEN) && (acc_add_q < acc_rem_q);
			len_q <= (ctl.out_kind == tto_pkg::OUT_LEN) ?
				acc_rem_q[tto_pkg::LEN_W-1:0] : '0;
		end
	end

	assign beneficial  = ben_q;
	assign tour_length = len_q;

endmodule

// ===== rtl/core/tto_ctrl.sv =====
`include "tour_two_opt_engine_assert.svh"

module tto_ctrl #(
	parameter int CITY_COUNT = tto_pkg::CITY_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tto_pkg::CMD_W-1:0]   cmd,
	input  logic [tto_pkg::IDX_W-1:0]   index_a,
	input  logic [tto_pkg::IDX_W-1:0]   index_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tto_pkg::dp_ctrl_t           ctl,
	input  tto_pkg::dp_stat_t           stat
);

	localparam int AW = (CITY_COUNT > 1) ? $clog2(CITY_COUNT) : 1;
	localparam logic [AW-1:0] LAST = AW'(CITY_COUNT - 1);

	tto_pkg::state_t state_q, state_d;

	logic [tto_pkg::CMD_W-1:0] cmd_q;
	logic [AW-1:0] i_q, j_q, a_q, b_q, p_q, n_q;
	logic [1:0]    step_q;
	logic          run_q;
	logic          out_valid_q;

	logic [tto_pkg::IDX_EXT_W-1:0] ia_ext, ib_ext, mn_ext, mx_ext;
	logic          a_ok, b_ok, same;
	logic [AW-1:0] ia, ib, mn, mx;
	logic [AW-1:0] addr1, addr2, k_next;
	logic          accept, go;

	assign ia_ext = tto_pkg::IDX_EXT_W'(index_a);
	assign ib_ext = tto_pkg::IDX_EXT_W'(index_b);
	assign mn_ext = (index_a < index_b) ? ia_ext : ib_ext;
	assign mx_ext = (index_a < index_b) ? ib_ext : ia_ext;
	assign a_ok   = ia_ext < tto_pkg::IDX_EXT_W'(CITY_COUNT);
	assign b_ok   = ib_ext < tto_pkg::IDX_EXT_W'(CITY_COUNT);
	assign same   = index_a == index_b;
	assign ia     = ia_ext[AW-1:0];
	assign ib     = ib_ext[AW-1:0];
	assign mn     = mn_ext[AW-1:0];
	assign mx     = mx_ext[AW-1:0];
	assign accept = in_valid && (state_q == tto_pkg::ST_IDLE);
	assign k_next = (i_q == LAST) ? '0 : AW'(i_q + 1'b1);

	// whether the accepted command needs the sequencer at all
	always_comb begin
		unique case (cmd)
			tto_pkg::CMD_SWAP: go = a_ok && b_ok && !same;
			tto_pkg::CMD_REV:  go = a_ok && b_ok && !same;
			tto_pkg::CMD_TEST: go = a_ok && b_ok && !same && !(mn == '0 && mx == LAST);
			tto_pkg::CMD_LEN:  go = 1'b1;
			default:           go = 1'b0;
		endcase
	end

	// edge endpoints for the current step
	always_comb begin
		addr1 = i_q;
		addr2 = j_q;
		if (cmd_q == tto_pkg::CMD_TEST) begin
			unique case (step_q)
				2'd0: begin addr1 = p_q; addr2 = a_q; end
				2'd1: begin addr1 = b_q; addr2 = n_q; end
				2'd2: begin addr1 = p_q; addr2 = b_q; end
				default: begin addr1 = a_q; addr2 = n_q; end
			endcase
		end else if (cmd_q == tto_pkg::CMD_LEN) begin
			addr2 = k_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tto_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
			run_q       <= 1'b0;
			step_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				cmd_q  <= cmd;
				run_q  <= go;
				step_q <= '0;
				if (cmd == tto_pkg::CMD_LEN) begin
					i_q <= '0;
				end else if (cmd == tto_pkg::CMD_SWAP) begin
					i_q <= ia;
					j_q <= ib;
				end else begin
					i_q <= mn;
					j_q <= mx;
				end
			end else if (state_q == tto_pkg::ST_WAIT && stat.dist_done) begin
				step_q <= 2'(step_q + 1'b1);
				i_q    <= k_next;
			end else if (state_q == tto_pkg::ST_WR2) begin
				i_q <= AW'(i_q + 1'b1);
				j_q <= AW'(j_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= mn;
			b_q <= mx;
			p_q <= (mn == '0) ? LAST : AW'(mn - 1'b1);
			n_q <= (mx == LAST) ? '0 : AW'(mx + 1'b1);
		end
	end

	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.rd_addr     = tto_pkg::ADDR_MAX_W'(addr1);
		ctl.wr_addr     = tto_pkg::ADDR_MAX_W'(addr1);
		ctl.acc_add_sel = (cmd_q == tto_pkg::CMD_TEST) && step_q[1];
		ctl.acc_sat     = cmd_q == tto_pkg::CMD_LEN;
		ctl.out_kind    = tto_pkg::OUT_NONE;
		unique case (state_q)
			tto_pkg::ST_IDLE: begin
				if (accept) begin
					ctl.wr_addr = tto_pkg::ADDR_MAX_W'(ia);
					ctl.acc_clr = 1'b1;
					if (cmd == tto_pkg::CMD_LOAD) begin
						ctl.wr_en   = a_ok;
						ctl.wr_load = 1'b1;
					end
					state_d = go ? tto_pkg::ST_RD1 : tto_pkg::ST_FIN;
				end
			end
			tto_pkg::ST_RD1: begin
				ctl.rd_en = 1'b1;
				state_d   = tto_pkg::ST_RD2;
			end
			tto_pkg::ST_RD2: begin
				ctl.cap1    = 1'b1;
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = tto_pkg::ADDR_MAX_W'(addr2);
				state_d     = tto_pkg::ST_CAP;
			end
			tto_pkg::ST_CAP: begin
				ctl.cap2 = 1'b1;
				if (cmd_q == tto_pkg::CMD_SWAP || cmd_q == tto_pkg::CMD_REV) begin
					state_d = tto_pkg::ST_WR1;
				end else begin
					state_d = tto_pkg::ST_DST;
				end
			end
			tto_pkg::ST_DST: begin
				ctl.dist_start = 1'b1;
				state_d        = tto_pkg::ST_WAIT;
			end
			tto_pkg::ST_WAIT: begin
				if (stat.dist_done) begin
					if (cmd_q == tto_pkg::CMD_TEST) begin
						state_d = (step_q == 2'd3) ? tto_pkg::ST_FIN : tto_pkg::ST_RD1;
					end else begin
						state_d = (i_q == LAST) ? tto_pkg::ST_FIN : tto_pkg::ST_RD1;
					end
				end
			end
			tto_pkg::ST_WR1: begin
				ctl.wr_en     = 1'b1;
				ctl.wr_src_p2 = 1'b1;
				state_d       = tto_pkg::ST_WR2;
			end
			tto_pkg::ST_WR2: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_addr = tto_pkg::ADDR_MAX_W'(addr2);
				// advance to the next inner pair while one remains
				if (cmd_q == tto_pkg::CMD_REV && ((AW+1)'(i_q) + (AW+1)'(2) < (AW+1)'(j_q))) begin
					state_d = tto_pkg::ST_RD1;
				end else begin
					state_d = tto_pkg::ST_FIN;
				end
			end
			tto_pkg::ST_FIN: begin
				if (cmd_q == tto_pkg::CMD_TEST && run_q) begin
					ctl.out_kind = tto_pkg::OUT_BEN;
				end else if (cmd_q == tto_pkg::CMD_LEN) begin
					ctl.out_kind = tto_pkg::OUT_LEN;
				end
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_d      = tto_pkg::ST_IDLE;
				end
			end
			default: state_d = tto_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = state_q != tto_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	`TTO_ASSERT_IMP(a_no_overwrite, clk, arst_n, ctl.out_load, !(out_valid_q && out_stall))
	`TTO_ASSERT_IMP(a_rev_order, clk, arst_n, (state_q == tto_pkg::ST_RD1 && cmd_q == tto_pkg::CMD_REV), i_q < j_q)
	`TTO_ASSERT_IMP(a_done_in_wait, clk, arst_n, stat.dist_done, state_q == tto_pkg::ST_WAIT)
	`TTO_ASSERT_NXT(a_start_waits, clk, arst_n, ctl.dist_start, state_q == tto_pkg::ST_WAIT)

endmodule

// ===== rtl/core/tour_two_opt_engine.sv =====
// 2-opt engine for a closed tour of CITY_COUNT cities held in on-chip memory. One command
// per transaction: load, swap, reverse, test gain or total length; every command returns
// one result transaction (fields zero where the command does not produce them). Each edge
// distance is floor(2^FRACTION_BITS * sqrt(dx^2+dy^2)) from a bit-serial square root that
// yields one root bit per cycle; one distance takes 2 memory reads, capture, start, 2 operand
// stages, COORD_BITS+FRACTION_BITS+1 root steps and a handoff. Test gain sums 4 distances,
// and total length sums CITY_COUNT distances. The next command is taken once the sequencer
// is back in idle, even while a result still waits.
module tour_two_opt_engine #(
	parameter int CITY_COUNT    = tto_pkg::CITY_COUNT_DEF,
	parameter int COORD_BITS    = tto_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = tto_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tto_pkg::CMD_W-1:0]   cmd,
	input  logic [tto_pkg::IDX_W-1:0]   index_a,
	input  logic [tto_pkg::IDX_W-1:0]   index_b,
	input  logic [tto_pkg::CITY_W-1:0]  city_x,
	input  logic [tto_pkg::CITY_W-1:0]  city_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        beneficial,
	output logic [tto_pkg::LEN_W-1:0]   tour_length
);

	tto_pkg::dp_ctrl_t ctl;
	tto_pkg::dp_stat_t stat;

	tto_ctrl #(
		.CITY_COUNT (CITY_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.index_a   (index_a),
		.index_b   (index_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	tto_datapath #(
		.CITY_COUNT    (CITY_COUNT),
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.city_x      (city_x),
		.city_y      (city_y),
		.beneficial  (beneficial),
		.tour_length (tour_length)
	);

endmodule
